// ----- src/scs1_pkg.sv -----
// shared types, constants and translation tables of the scancode key queue
package scs1_pkg;

  localparam int unsigned QueueDepthDefault = 128;
  localparam int unsigned CodeW = 16;
  localparam int unsigned NumExt = 7;
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  typedef enum logic [1:0] {
    OP_SCAN = 2'd0,
    OP_KEY  = 2'd1,
    OP_CHAR = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_KEY     = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_DISCARD = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    REG_LEFT   = 3'd0,
    REG_RIGHT  = 3'd1,
    REG_UP     = 3'd2,
    REG_DOWN   = 3'd3,
    REG_HOME   = 3'd4,
    REG_END    = 3'd5,
    REG_DELETE = 3'd6,
    REG_NONE   = 3'd7
  } reg_idx_e;

  localparam logic [7:0] ScPrefix   = 8'hE0;
  localparam logic [6:0] ScLShift   = 7'h2A;
  localparam logic [6:0] ScRShift   = 7'h36;
  localparam logic [6:0] ScCaps     = 7'h3A;
  localparam logic [6:0] ScEnter    = 7'h1C;
  localparam logic [6:0] ScBack     = 7'h0E;
  localparam logic [6:0] ScLeft     = 7'h4B;
  localparam logic [6:0] ScRight    = 7'h4D;
  localparam logic [6:0] ScUp       = 7'h48;
  localparam logic [6:0] ScDown     = 7'h50;
  localparam logic [6:0] ScHome     = 7'h47;
  localparam logic [6:0] ScEnd      = 7'h4F;
  localparam logic [6:0] ScDelete   = 7'h53;
  localparam logic [6:0] TabLen     = 7'd58;
  localparam logic [7:0] AsciiLf    = 8'd10;
  localparam logic [7:0] AsciiBs    = 8'd8;

  localparam logic [NumExt-1:0][CodeW-1:0] ExtReset = {
    16'd262, 16'd261, 16'd260, 16'd259, 16'd258, 16'd257, 16'd256
  };

  typedef struct packed {
    logic             valid;
    logic [CodeW-1:0] code;
  } push_t;

  localparam logic [7:0] PlainTab [58] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h5C, 8'h00, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
    8'h00, 8'h20
  };

  localparam logic [7:0] ShiftTab [58] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h7C, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
    8'h00, 8'h20
  };

  function automatic logic [7:0] translate(input logic [6:0] c, input logic sh,
                                           input logic caps);
    logic letter;
    logic up;
    logic [7:0] res;
    letter = (c >= 7'h10 && c <= 7'h19) || (c >= 7'h1E && c <= 7'h26) ||
             (c >= 7'h2C && c <= 7'h32);
    up = letter ? (caps ^ sh) : sh;
    if (c == ScEnter) begin
      res = AsciiLf;
    end else if (c == ScBack) begin
      res = AsciiBs;
    end else if (c >= TabLen) begin
      res = 8'd0;
    end else if (up) begin
      res = ShiftTab[c[5:0]];
    end else begin
      res = PlainTab[c[5:0]];
    end
    return res;
  endfunction

endpackage

// ----- src/scs1_if.sv -----
// valid/ready channel interfaces for input items and results
interface scs1_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] scan_byte;
  modport source (output valid, output opcode, output scan_byte, input ready);
  modport sink (input valid, input opcode, input scan_byte, output ready);
endinterface

interface scs1_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  read_status;
  logic [15:0] key_code;
  modport source (output valid, output read_status, output key_code, input ready);
  modport sink (input valid, input read_status, input key_code, output ready);
endinterface

// ----- src/scs1_decode.sv -----
// scancode byte decoder with shift, caps lock and prefix tracking
module scs1_decode (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              scan_valid_i,
  input  logic [7:0]                                        scan_byte_i,
  input  logic [scs1_pkg::NumExt-1:0][scs1_pkg::CodeW-1:0]  ext_codes_i,
  output scs1_pkg::push_t                                   push_o
);

  logic lshift_q, lshift_d;
  logic rshift_q, rshift_d;
  logic caps_q, caps_d;
  logic prefix_q, prefix_d;
  logic       rel;
  logic [6:0] c;
  logic [7:0] ch;

  always_comb begin
    lshift_d = lshift_q;
    rshift_d = rshift_q;
    caps_d   = caps_q;
    prefix_d = prefix_q;
    push_o   = '0;
    rel      = scan_byte_i[7];
    c        = scan_byte_i[6:0];
    ch       = scs1_pkg::translate(c, lshift_q | rshift_q, caps_q);
    if (scan_valid_i) begin
      priority if (scan_byte_i == scs1_pkg::ScPrefix) begin
        prefix_d = 1'b1;
      end else if (prefix_q) begin
        prefix_d = 1'b0;
        if (!rel) begin
          push_o.valid = 1'b1;
          unique case (c)
            scs1_pkg::ScLeft:   push_o.code = ext_codes_i[scs1_pkg::REG_LEFT];
            scs1_pkg::ScRight:  push_o.code = ext_codes_i[scs1_pkg::REG_RIGHT];
            scs1_pkg::ScUp:     push_o.code = ext_codes_i[scs1_pkg::REG_UP];
            scs1_pkg::ScDown:   push_o.code = ext_codes_i[scs1_pkg::REG_DOWN];
            scs1_pkg::ScHome:   push_o.code = ext_codes_i[scs1_pkg::REG_HOME];
            scs1_pkg::ScEnd:    push_o.code = ext_codes_i[scs1_pkg::REG_END];
            scs1_pkg::ScDelete: push_o.code = ext_codes_i[scs1_pkg::REG_DELETE];
            default:            push_o.valid = 1'b0;
          endcase
        end
      end else if (rel) begin
        if (c == scs1_pkg::ScLShift) begin
          lshift_d = 1'b0;
        end else if (c == scs1_pkg::ScRShift) begin
          rshift_d = 1'b0;
        end
      end else if (c == scs1_pkg::ScLShift) begin
        lshift_d = 1'b1;
      end else if (c == scs1_pkg::ScRShift) begin
        rshift_d = 1'b1;
      end else if (c == scs1_pkg::ScCaps) begin
        caps_d = ~caps_q;
      end else begin
        push_o.valid = (ch != 8'd0);
        push_o.code  = {{(scs1_pkg::CodeW - 8){1'b0}}, ch};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lshift_q <= 1'b0;
      rshift_q <= 1'b0;
      caps_q   <= 1'b0;
      prefix_q <= 1'b0;
    end else begin
      lshift_q <= lshift_d;
      rshift_q <= rshift_d;
      caps_q   <= caps_d;
      prefix_q <= prefix_d;
    end
  end

endmodule

// ----- src/scs1_ring.sv -----
// ring queue of key codes in a synchronous memory with read and write pointers
module scs1_ring #(
  parameter int unsigned QUEUE_DEPTH = scs1_pkg::QueueDepthDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  scs1_pkg::push_t            push_i,
  input  logic                       pop_i,
  output logic                       empty_o,
  output logic [scs1_pkg::CodeW-1:0] rdata_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);

  logic [scs1_pkg::CodeW-1:0] mem [QUEUE_DEPTH];
  logic [PtrW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [PtrW-1:0] wp_next, rp_next;
  logic            wr_en;

  assign wp_next = (wp_q == PtrLast) ? '0 : wp_q + 1'b1;
  assign rp_next = (rp_q == PtrLast) ? '0 : rp_q + 1'b1;
  assign empty_o = (wp_q == rp_q);
  assign wr_en   = push_i.valid && (wp_next != rp_q);

  always_comb begin
    wp_d = wr_en ? wp_next : wp_q;
    rp_d = pop_i ? rp_next : rp_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
    end else begin
      wp_q <= wp_d;
      rp_q <= rp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wp_q] <= push_i.code;
    end
    if (pop_i) begin
      rdata_o <= mem[rp_q];
    end
  end

endmodule

// ----- src/scancode_set1_key_queue.sv -----
// top level of the scancode set 1 decoder and key queue
//
// channel  dir  transfer when     payload
// in_if    in   valid && ready    opcode, scan_byte
// out_if   out  valid && ready    read_status, key_code
// apb      in   psel && penable   paddr, pwdata, prdata
//
// one item per cycle: an accepted item's memory read lands in the read stage
// register and the result moves from there to the output register; a new
// item is taken each cycle while the output register drains. reset clears
// pointers, shift, caps lock and prefix state; the ring memory itself is not
// cleared. a stalled output holds one result and one item in the read stage.
module scancode_set1_key_queue #(
  parameter int unsigned QUEUE_DEPTH = scs1_pkg::QueueDepthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  scs1_in_if.sink                      in_if,
  scs1_out_if.source                   out_if,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [scs1_pkg::AddrW-1:0]   paddr,
  input  logic [scs1_pkg::DataW-1:0]   pwdata,
  output logic [scs1_pkg::DataW-1:0]   prdata,
  output logic                         pready
);

  logic [scs1_pkg::NumExt-1:0][scs1_pkg::CodeW-1:0] ext_q;
  scs1_pkg::reg_idx_e cfg_idx;
  logic               cfg_wr;

  scs1_pkg::op_e      in_op;
  logic               accept;
  logic               move;
  logic               empty;
  logic               pop;
  logic [scs1_pkg::CodeW-1:0] rdata;
  scs1_pkg::push_t    push;

  logic               busy_q, busy_d;
  scs1_pkg::op_e      stg_op_q;
  logic               stg_empty_q;

  logic                       out_valid_q, out_valid_d;
  scs1_pkg::status_e          out_status_q, res_status;
  logic [scs1_pkg::CodeW-1:0] out_code_q, res_code;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_idx = scs1_pkg::reg_idx_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    if (cfg_idx != scs1_pkg::REG_NONE) begin
      prdata = {{(scs1_pkg::DataW - scs1_pkg::CodeW){1'b0}}, ext_q[cfg_idx]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_q <= scs1_pkg::ExtReset;
    end else if (cfg_wr && cfg_idx != scs1_pkg::REG_NONE) begin
      ext_q[cfg_idx] <= pwdata[scs1_pkg::CodeW-1:0];
    end
  end

  // input side
  assign in_op       = scs1_pkg::op_e'(in_if.opcode);
  assign move        = busy_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !busy_q || move;
  assign accept      = in_if.valid && in_if.ready;
  assign pop         = accept && !empty &&
                       (in_op == scs1_pkg::OP_KEY || in_op == scs1_pkg::OP_CHAR);

  scs1_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .scan_valid_i (accept && in_op == scs1_pkg::OP_SCAN),
    .scan_byte_i  (in_if.scan_byte),
    .ext_codes_i  (ext_q),
    .push_o       (push)
  );

  scs1_ring #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (rdata)
  );

  // read stage
  always_comb begin
    res_status = scs1_pkg::ST_NONE;
    res_code   = '0;
    unique case (stg_op_q)
      scs1_pkg::OP_KEY, scs1_pkg::OP_CHAR: begin
        priority if (stg_empty_q) begin
          res_status = scs1_pkg::ST_EMPTY;
        end else if (stg_op_q == scs1_pkg::OP_CHAR && (|rdata[scs1_pkg::CodeW-1:8])) begin
          res_status = scs1_pkg::ST_DISCARD;
        end else begin
          res_status = scs1_pkg::ST_KEY;
          res_code   = rdata;
        end
      end
      scs1_pkg::OP_SCAN, scs1_pkg::OP_NONE: begin
        res_status = scs1_pkg::ST_NONE;
      end
      default: res_status = scs1_pkg::ST_NONE;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (move) begin
      busy_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (move) begin
      out_valid_d = 1'b1;
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_op_q    <= in_op;
      stg_empty_q <= empty;
    end
    if (move) begin
      out_status_q <= res_status;
      out_code_q   <= res_code;
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.read_status = out_status_q;
  assign out_if.key_code    = out_code_q;

`ifndef SYNTHESIS
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q)
    else $error("accepted item missing from read stage");

  a_move_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    move |=> out_valid_q)
    else $error("moved result not presented");

  a_code_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q != scs1_pkg::ST_KEY |-> out_code_q == '0)
    else $error("nonzero key code without delivered key");
`endif

endmodule

// ----- sim/tb_scancode_set1_key_queue.sv -----
// self-checking testbench of the scancode set 1 key queue with a predicting scoreboard
`timescale 1ns / 1ps

module tb_scancode_set1_key_queue;
  import scs1_pkg::*;

  localparam int unsigned QDepth      = QueueDepthDefault;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 6;
  localparam logic [7:0]  RelBit      = 8'h80;
  localparam int unsigned CharLimit   = 256;

  localparam logic [7:0] UnshiftedChars [58] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h5C, 8'h00, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
    8'h00, 8'h20
  };

  localparam logic [7:0] ShiftedChars [58] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h7C, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
    8'h00, 8'h20
  };

  localparam logic [6:0] ExtScans [NumExt] = '{
    ScLeft, ScRight, ScUp, ScDown, ScHome, ScEnd, ScDelete
  };

  typedef struct packed {
    status_e          st;
    logic [CodeW-1:0] code;
  } key_result_t;

  class key_queue_scoreboard;
    logic [CodeW-1:0] ring [QDepth];
    int unsigned      wr_ptr;
    int unsigned      rd_ptr;
    bit               lshift;
    bit               rshift;
    bit               caps;
    bit               ext_pending;
    logic [CodeW-1:0] ext_code [NumExt];
    key_result_t      expected_results [$];
    int unsigned      errors;

    function new();
      wr_ptr = 0;
      rd_ptr = 0;
      lshift = 1'b0;
      rshift = 1'b0;
      caps = 1'b0;
      ext_pending = 1'b0;
      errors = 0;
      foreach (ext_code[i]) ext_code[i] = ExtReset[i];
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function void push_code(logic [CodeW-1:0] k);
      int unsigned nxt;
      nxt = (wr_ptr + 1) % QDepth;
      if (nxt != rd_ptr) begin
        ring[wr_ptr] = k;
        wr_ptr = nxt;
      end
    endfunction

    function logic [7:0] to_char(logic [6:0] c);
      bit letter;
      bit up;
      letter = (c >= 7'h10 && c <= 7'h19) || (c >= 7'h1E && c <= 7'h26) ||
               (c >= 7'h2C && c <= 7'h32);
      up = letter ? (caps != (lshift || rshift)) : (lshift || rshift);
      if (c == ScEnter) return AsciiLf;
      if (c == ScBack) return AsciiBs;
      if (c >= TabLen) return 8'h00;
      return up ? ShiftedChars[c] : UnshiftedChars[c];
    endfunction

    function void take_scan(logic [7:0] b);
      logic       rel;
      logic [6:0] c;
      logic [7:0] ch;
      rel = b[7];
      c = b[6:0];
      if (b == ScPrefix) begin
        ext_pending = 1'b1;
      end else if (ext_pending) begin
        ext_pending = 1'b0;
        if (!rel) begin
          case (c)
            ScLeft:   push_code(ext_code[REG_LEFT]);
            ScRight:  push_code(ext_code[REG_RIGHT]);
            ScUp:     push_code(ext_code[REG_UP]);
            ScDown:   push_code(ext_code[REG_DOWN]);
            ScHome:   push_code(ext_code[REG_HOME]);
            ScEnd:    push_code(ext_code[REG_END]);
            ScDelete: push_code(ext_code[REG_DELETE]);
            default: ;
          endcase
        end
      end else if (rel) begin
        if (c == ScLShift) lshift = 1'b0;
        else if (c == ScRShift) rshift = 1'b0;
      end else if (c == ScLShift) begin
        lshift = 1'b1;
      end else if (c == ScRShift) begin
        rshift = 1'b1;
      end else if (c == ScCaps) begin
        caps = !caps;
      end else begin
        ch = to_char(c);
        if (ch != 8'h00) push_code({8'h00, ch});
      end
    endfunction

    function void note_item(op_e op, logic [7:0] b);
      key_result_t res;
      res.st = ST_NONE;
      res.code = '0;
      case (op)
        OP_SCAN: take_scan(b);
        OP_KEY, OP_CHAR: begin
          if (wr_ptr == rd_ptr) begin
            res.st = ST_EMPTY;
          end else begin
            res.code = ring[rd_ptr];
            rd_ptr = (rd_ptr + 1) % QDepth;
            if (op == OP_CHAR && res.code >= CharLimit) begin
              res.st = ST_DISCARD;
              res.code = '0;
            end else begin
              res.st = ST_KEY;
            end
          end
        end
        default: ;
      endcase
      expected_results.push_back(res);
    endfunction

    task report_mismatch(string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(status_e st, logic [CodeW-1:0] code);
      key_result_t exp_res;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d code %0d", st, code));
      end else begin
        exp_res = expected_results.pop_front();
        if (st !== exp_res.st)
          report_mismatch($sformatf("status %0d, want %0d", st, exp_res.st));
        if (code !== exp_res.code)
          report_mismatch($sformatf("key code %0d, want %0d", code, exp_res.code));
      end
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;

  scs1_in_if  in_ch ();
  scs1_out_if out_ch ();

  key_queue_scoreboard sb = new();

  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned items_sent = 0;
  int unsigned cycles = 0;

  scancode_set1_key_queue u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("scancode_set1_key_queue regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      sb.check_result(status_e'(out_ch.read_status), out_ch.key_code);
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
      end else begin
        out_ch.ready <= !(idle_on && $urandom_range(0, 99) < 10);
      end
    end
  end

  task send_item(op_e op, logic [7:0] b);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 99) < 4) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.scan_byte <= b;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_item(op, b);
    items_sent++;
  endtask

  task wait_drained();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task apb_write(reg_idx_e idx, logic [CodeW-1:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {{(DataW - CodeW){1'b0}}, val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.ext_code[idx] = val;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task check_codes();
    reg_idx_e idx;
    for (int i = 0; i < NumExt; i++) begin
      idx = reg_idx_e'(i);
      @(negedge clk_i);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {idx, 2'b00};
      @(negedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      if (prdata[CodeW-1:0] !== sb.ext_code[idx])
        sb.report_mismatch($sformatf("register %s reads %0d, want %0d",
                                     idx.name(), prdata[CodeW-1:0], sb.ext_code[idx]));
      @(negedge clk_i);
      psel <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  task program_codes(logic [CodeW-1:0] vals [NumExt]);
    for (int i = 0; i < NumExt; i++) apb_write(reg_idx_e'(i), vals[i]);
    check_codes();
  endtask

  task send_typing();
    int unsigned r;
    logic [6:0]  c;
    repeat ($urandom_range(1, 12)) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        c = $urandom_range(0, 1) ? ScLShift : ScRShift;
        send_item(OP_SCAN, {1'($urandom_range(0, 1)), c});
      end else if (r < 15) begin
        send_item(OP_SCAN, {1'b0, ScCaps});
      end else begin
        c = ($urandom_range(0, 9) < 7) ? 7'($urandom_range(0, 57)) : 7'($urandom_range(0, 127));
        send_item(OP_SCAN, {1'($urandom_range(0, 99) < 30), c});
      end
    end
  endtask

  task send_extended();
    int unsigned r;
    logic [6:0]  c;
    send_item(OP_SCAN, ScPrefix);
    r = $urandom_range(0, 99);
    c = ExtScans[$urandom_range(0, NumExt - 1)];
    if (r < 70) send_item(OP_SCAN, {1'b0, c});
    else if (r < 85) send_item(OP_SCAN, RelBit | {1'b0, c});
    else send_item(OP_SCAN, 8'($urandom_range(0, 255)));
  endtask

  task send_reads(int unsigned n);
    repeat (n) send_item($urandom_range(0, 1) ? OP_KEY : OP_CHAR, 8'($urandom_range(0, 255)));
  endtask

  task send_noise();
    repeat ($urandom_range(1, 4))
      send_item(op_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
  endtask

  // overfill the ring with letters, then empty it past the bottom
  task send_fill();
    repeat (QDepth + 7) send_item(OP_SCAN, {1'b0, 7'($urandom_range(16, 25))});
    send_reads(QDepth + 3);
  endtask

  task run_random(int unsigned upto);
    int unsigned pick;
    while (items_sent < upto) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) send_typing();
      else if (pick < 55) send_extended();
      else if (pick < 85) send_reads($urandom_range(1, 10));
      else send_noise();
    end
  endtask

  initial begin
    logic [CodeW-1:0] vals [NumExt];
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_SCAN;
    in_ch.scan_byte = 8'h00;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    check_codes();

    // directed: empty reads, prefix handling, shift and caps, special keys
    send_item(OP_KEY, 8'h00);
    send_item(OP_CHAR, 8'h00);
    send_item(OP_NONE, 8'hFF);
    send_item(OP_SCAN, ScPrefix);
    send_item(OP_SCAN, ScPrefix);
    send_item(OP_SCAN, {1'b0, ScLeft});
    send_item(OP_CHAR, 8'h00);
    send_item(OP_SCAN, ScPrefix);
    send_item(OP_SCAN, RelBit | {1'b0, ScLeft});
    send_item(OP_SCAN, ScPrefix);
    send_item(OP_SCAN, {1'b0, ScLShift});
    send_item(OP_SCAN, 8'h1E);
    send_item(OP_SCAN, {1'b0, ScLShift});
    send_item(OP_SCAN, 8'h1E);
    send_item(OP_SCAN, RelBit | {1'b0, ScLShift});
    send_item(OP_SCAN, {1'b0, ScCaps});
    send_item(OP_SCAN, {1'b0, ScRShift});
    send_item(OP_SCAN, 8'h02);
    send_item(OP_SCAN, 8'h10);
    send_item(OP_SCAN, {1'b0, ScEnter});
    send_item(OP_SCAN, {1'b0, ScBack});
    send_item(OP_SCAN, 8'h00);
    send_item(OP_SCAN, 8'h7F);
    send_item(OP_KEY, 8'hFF);
    send_item(OP_CHAR, 8'h00);

    run_random(items_sent + 250);
    wait_drained();

    vals = '{16'd0, 16'hFFFF, 16'd255, 16'd256, 16'd1, 16'h7FFF, 16'h8000};
    program_codes(vals);
    idle_on = 1'b0;
    run_random(items_sent + 250);
    idle_on = 1'b1;
    send_fill();
    run_random(items_sent + 150);
    wait_drained();

    foreach (vals[i]) vals[i] = 16'($urandom_range(0, 65535));
    program_codes(vals);
    hold_req = 1'b1;
    run_random(items_sent + 300);
    wait_drained();
    run_random(items_sent + 150);
    wait_drained();

    foreach (vals[i]) vals[i] = 16'($urandom_range(0, 511));
    vals[$urandom_range(0, NumExt - 1)] = 16'hFFFF;
    program_codes(vals);
    run_random(items_sent + 150);
    send_fill();
    run_random(items_sent + 100);
    wait_drained();

    if (sb.errors == 0) begin
      $display("scancode_set1_key_queue regression: pass");
    end else begin
      $display("scancode_set1_key_queue regression: fail");
    end
    $finish;
  end

endmodule
